// ===== rtl/pwh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_pkg
// Shared types, constants and helpers of the piecewise harmonic pair force
// block.
// ----------------------------------------------------------------------------
package pwh_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRAC_BITS     = 16;
  localparam int REG_WIDTH     = 31;
  localparam int DIR_BITS      = 30;
  localparam int NORM_BITS     = 32;
  localparam int EMAG_WIDTH    = 60;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_WIDTH     = 64;
  localparam int DIVISOR_WIDTH = 32;
  localparam int DIV_STEPS     = DIV_WIDTH;
  localparam int FRONT_LAT     = SQRT_STEPS + DIV_STEPS + 4;
  localparam int ITEM_DLY      = 2 * DIV_STEPS + 2;
  localparam int BACK_LAT      = ITEM_DLY + 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;

  localparam logic [1:0] CFG_SPRING  = 2'd0;
  localparam logic [1:0] CFG_DESIRED = 2'd1;
  localparam logic [1:0] CFG_CUTOFF  = 2'd2;
  localparam logic [1:0] CFG_DEPTH   = 2'd3;

  localparam logic [REG_WIDTH-1:0] SPRING_RST  = 31'd65536;
  localparam logic [REG_WIDTH-1:0] DESIRED_RST = 31'd65536;
  localparam logic [REG_WIDTH-1:0] CUTOFF_RST  = 31'd131072;
  localparam logic [REG_WIDTH-1:0] DEPTH_RST   = 31'd65536;

  typedef enum logic [1:0] {
    REGION_NONE  = 2'd0,
    REGION_REP   = 2'd1,
    REGION_INNER = 2'd2,
    REGION_OUTER = 2'd3
  } region_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] spring;
    logic [REG_WIDTH-1:0] desired;
    logic [REG_WIDTH-1:0] cutoff;
    logic [REG_WIDTH-1:0] depth;
  } cfg_t;

  typedef struct packed {
    region_t               region;
    logic [31:0]           distance;
    logic [2:0]            xneg;
    logic [2:0][DIR_BITS:0] dir;
  } pair_item_t;

  // returns {clipped, value}
  function automatic logic [VALUE_WIDTH:0] clip_signed(input logic neg,
                                                      input logic [EMAG_WIDTH-1:0] mag);
    logic [EMAG_WIDTH-1:0] lim;
    logic [EMAG_WIDTH-1:0] m;
    logic                  sat;
    lim = '0;
    lim[VALUE_WIDTH-1] = 1'b1;
    if (!neg) begin
      lim = lim - 1'b1;
    end
    sat = mag > lim;
    m = sat ? lim : mag;
    if (neg) begin
      m = '0 - m;
    end
    return {sat, m[VALUE_WIDTH-1:0]};
  endfunction

endpackage

// ===== rtl/pwh_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pwh_sqrt import pwh_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_n  [SQRT_STEPS];
  logic [31:0] root_n [SQRT_STEPS];
  logic [63:0] rad_n  [SQRT_STEPS];

  always_comb begin
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] rad_i;
    logic [35:0] cur;
    logic [35:0] trial;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (j == 0) begin
        rem_i  = '0;
        root_i = '0;
        rad_i  = radicand;
      end else begin
        rem_i  = rem_q[j-1];
        root_i = root_q[j-1];
        rad_i  = rad_q[j-1];
      end
      cur   = {rem_i, rad_i[63:62]};
      trial = {2'b00, root_i, 2'b01};
      if (cur >= trial) begin
        rem_n[j]  = 34'(cur - trial);
        root_n[j] = {root_i[30:0], 1'b1};
      end else begin
        rem_n[j]  = cur[33:0];
        root_n[j] = {root_i[30:0], 1'b0};
      end
      rad_n[j] = {rad_i[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_q[j]  <= rem_n[j];
        root_q[j] <= root_n[j];
        rad_q[j]  <= rad_n[j];
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

// ===== rtl/pwh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pwh_div import pwh_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DIV_WIDTH-1:0]     dividend,
  input  logic [DIVISOR_WIDTH-1:0] divisor,
  output logic [DIV_WIDTH-1:0]     quotient
);

  logic [DIVISOR_WIDTH-1:0] rem_q [DIV_STEPS];
  logic [DIV_WIDTH-1:0]     qd_q  [DIV_STEPS];
  logic [DIVISOR_WIDTH-1:0] dv_q  [DIV_STEPS];
  logic [DIVISOR_WIDTH-1:0] rem_n [DIV_STEPS];
  logic [DIV_WIDTH-1:0]     qd_n  [DIV_STEPS];

  always_comb begin
    logic [DIVISOR_WIDTH-1:0] rem_i;
    logic [DIVISOR_WIDTH-1:0] dv_i;
    logic [DIV_WIDTH-1:0]     qd_i;
    logic [DIVISOR_WIDTH:0]   cur;
    logic [DIVISOR_WIDTH:0]   diff;
    logic                     ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        rem_i = '0;
        qd_i  = dividend;
        dv_i  = divisor;
      end else begin
        rem_i = rem_q[j-1];
        qd_i  = qd_q[j-1];
        dv_i  = dv_q[j-1];
      end
      cur  = {rem_i, qd_i[DIV_WIDTH-1]};
      diff = cur - {1'b0, dv_i};
      ge   = cur >= {1'b0, dv_i};
      rem_n[j] = ge ? diff[DIVISOR_WIDTH-1:0] : cur[DIVISOR_WIDTH-1:0];
      qd_n[j]  = {qd_i[DIV_WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_q[j] <= rem_n[j];
        qd_q[j]  <= qd_n[j];
        dv_q[j]  <= (j == 0) ? divisor : dv_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign quotient = qd_q[DIV_STEPS-1];

endmodule

// ===== rtl/pwh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_front
// Distance, region and unit direction of each pair displacement.
// ----------------------------------------------------------------------------
module pwh_front import pwh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0][31:0] in_disp,
  output logic            out_valid,
  input  logic            out_ready,
  output pair_item_t      out_item
);

  logic                 en;
  logic [FRONT_LAT-1:0] vld;
  logic [2:0][31:0]     a_mag, b_mag, c_mag, d_mag;
  logic [2:0]           a_neg, b_neg, c_neg, d_neg;
  logic [2:0][63:0]     b_sq;
  logic [63:0]          c_sum;
  logic [2:0][31:0]     s_mag [SQRT_STEPS];
  logic [2:0]           s_neg [SQRT_STEPS];
  logic [31:0]          root;
  region_t              region;
  logic [31:0]          d_dist;
  region_t              d_region;
  logic [31:0]          l_dist   [DIV_STEPS];
  region_t              l_region [DIV_STEPS];
  logic [2:0]           l_neg    [DIV_STEPS];
  logic [2:0][63:0]     quot;

  assign en       = !vld[FRONT_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    if (root < {1'b0, cfg.desired}) begin
      region = REGION_REP;
    end else if ({root, 1'b0} < ({2'b00, cfg.cutoff} + {2'b00, cfg.desired})) begin
      region = REGION_INNER;
    end else if (root < {1'b0, cfg.cutoff}) begin
      region = REGION_OUTER;
    end else begin
      region = REGION_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_disp[i][31];
        a_mag[i] <= in_disp[i][31] ? (~in_disp[i] + 32'd1) : in_disp[i];
        b_sq[i]  <= a_mag[i] * a_mag[i];
      end
      b_mag    <= a_mag;
      b_neg    <= a_neg;
      c_sum    <= b_sq[0] + b_sq[1] + b_sq[2];
      c_mag    <= b_mag;
      c_neg    <= b_neg;
      s_mag[0] <= c_mag;
      s_neg[0] <= c_neg;
      for (int j = 1; j < SQRT_STEPS; j++) begin
        s_mag[j] <= s_mag[j-1];
        s_neg[j] <= s_neg[j-1];
      end
      d_dist      <= root;
      d_region    <= region;
      d_mag       <= s_mag[SQRT_STEPS-1];
      d_neg       <= s_neg[SQRT_STEPS-1];
      l_dist[0]   <= d_dist;
      l_region[0] <= d_region;
      l_neg[0]    <= d_neg;
      for (int j = 1; j < DIV_STEPS; j++) begin
        l_dist[j]   <= l_dist[j-1];
        l_region[j] <= l_region[j-1];
        l_neg[j]    <= l_neg[j-1];
      end
    end
  end

  pwh_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (c_sum),
    .root     (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_dir
    pwh_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({2'b00, d_mag[i], {DIR_BITS{1'b0}}}),
      .divisor  (d_dist),
      .quotient (quot[i])
    );
  end

  always_comb begin
    out_item.region   = l_region[DIV_STEPS-1];
    out_item.distance = l_dist[DIV_STEPS-1];
    out_item.xneg     = l_neg[DIV_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      out_item.dir[i] = (l_dist[DIV_STEPS-1] == '0) ? '0 : quot[i][DIR_BITS:0];
    end
  end

  assign out_valid = vld[FRONT_LAT-1];

endmodule

// ===== rtl/pwh_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_fifo
// Short queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module pwh_fifo import pwh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pair_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output pair_item_t out_item
);

  pair_item_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic [QUEUE_AW:0]   count_next;
  logic                push;
  logic                pop;

  assign in_ready  = count != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/pwh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwh_back
// Force factor, energy and force vector of each classified pair.
// ----------------------------------------------------------------------------
module pwh_back import pwh_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pair_item_t                  in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0][VALUE_WIDTH-1:0] out_force,
  output logic [VALUE_WIDTH-1:0]      out_energy,
  output region_t                     out_region,
  output logic                        out_sat
);

  logic                 en;
  logic [BACK_LAT-1:0]  vld;
  pair_item_t           it_q [ITEM_DLY];
  logic [30:0]          e_a23;
  logic [30:0]          span;
  logic [30:0]          a1;
  logic [63:0]          u_quot;
  logic [63:0]          f_quot;
  logic [31:0]          g_u;
  logic [62:0]          g_wu;
  logic [31:0]          u_dly [DIV_STEPS];
  pair_item_t           t1_item, t2_item, t3_item, t4_item;
  logic [61:0]          t1_ka, t1_aa;
  logic [63:0]          t1_uu;
  logic [47:0]          t1_fac23;
  logic [47:0]          t2_fac, fac_next;
  logic [62:0]          t2_plo, t2_tw;
  logic [60:0]          t2_phi;
  logic [2:0][62:0]     t3_flo;
  logic [2:0][46:0]     t3_fhi;
  logic [59:0]          t3_t1;
  logic [31:0]          t3_t23;
  logic [93:0]          esum;
  logic [2:0][48:0]     t4_fm;
  logic [2:0][78:0]     fsum;
  logic [EMAG_WIDTH-1:0] t4_emag, emag_next;
  logic                 t4_eneg, eneg_next;
  logic [2:0][VALUE_WIDTH:0] fclip;
  logic [VALUE_WIDTH:0] eclip;

  assign en        = !vld[BACK_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[BACK_LAT-1];
  assign span      = cfg.cutoff - cfg.desired;
  assign a1        = cfg.desired - it_q[ITEM_DLY-1].distance[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_LAT-2:0], in_valid};
    end
  end

  pwh_div u_norm_div (
    .clk      (clk),
    .en       (en),
    .dividend ({1'b0, e_a23, {NORM_BITS{1'b0}}}),
    .divisor  ({1'b0, span}),
    .quotient (u_quot)
  );

  pwh_div u_fac_div (
    .clk      (clk),
    .en       (en),
    .dividend ({1'b0, g_wu}),
    .divisor  ({1'b0, span}),
    .quotient (f_quot)
  );

  always_comb begin
    case (t1_item.region)
      REGION_REP:                 fac_next = {2'b00, t1_ka[61:FRAC_BITS]};
      REGION_INNER, REGION_OUTER: fac_next = t1_fac23;
      default:                    fac_next = '0;
    endcase
  end

  always_comb begin
    esum = {31'd0, t2_plo} + {1'b0, t2_phi, 32'd0};
    for (int i = 0; i < 3; i++) begin
      fsum[i] = {16'd0, t3_flo[i]} + {t3_fhi[i], 32'd0};
    end
  end

  always_comb begin
    emag_next = '0;
    eneg_next = 1'b0;
    case (t3_item.region)
      REGION_REP: begin
        if (t3_t1 >= {29'd0, cfg.depth}) begin
          emag_next = t3_t1 - {29'd0, cfg.depth};
        end else begin
          emag_next = {29'd0, cfg.depth} - t3_t1;
          eneg_next = 1'b1;
        end
      end
      REGION_INNER: begin
        emag_next = {29'd0, cfg.depth} - {28'd0, t3_t23};
        eneg_next = 1'b1;
      end
      REGION_OUTER: begin
        emag_next = {28'd0, t3_t23};
        eneg_next = 1'b1;
      end
      default: begin
        emag_next = '0;
        eneg_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fclip[i] = clip_signed((t4_item.region == REGION_REP) ^ t4_item.xneg[i],
                             {11'd0, t4_fm[i]});
    end
    eclip = clip_signed(t4_eneg && (t4_emag != '0), t4_emag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_q[0] <= in_item;
      e_a23   <= (in_item.region == REGION_INNER) ?
                 31'(in_item.distance - {1'b0, cfg.desired}) :
                 31'({1'b0, cfg.cutoff} - in_item.distance);
      for (int j = 1; j < ITEM_DLY; j++) begin
        it_q[j] <= it_q[j-1];
      end
      g_u      <= u_quot[31:0];
      g_wu     <= cfg.depth * u_quot[31:0];
      u_dly[0] <= g_u;
      for (int j = 1; j < DIV_STEPS; j++) begin
        u_dly[j] <= u_dly[j-1];
      end
      t1_item  <= it_q[ITEM_DLY-1];
      t1_ka    <= cfg.spring * a1;
      t1_aa    <= a1 * a1;
      t1_uu    <= u_dly[DIV_STEPS-1] * u_dly[DIV_STEPS-1];
      t1_fac23 <= f_quot[61:NORM_BITS-2-FRAC_BITS];
      t2_item  <= t1_item;
      t2_fac   <= fac_next;
      t2_plo   <= cfg.spring * t1_aa[31:0];
      t2_phi   <= cfg.spring * t1_aa[61:32];
      t2_tw    <= cfg.depth * t1_uu[63:32];
      t3_item  <= t2_item;
      for (int i = 0; i < 3; i++) begin
        t3_flo[i] <= t2_fac[31:0] * t2_item.dir[i];
        t3_fhi[i] <= t2_fac[47:32] * t2_item.dir[i];
      end
      t3_t1    <= esum[2*FRAC_BITS+1 +: EMAG_WIDTH];
      t3_t23   <= t2_tw[62:31];
      t4_item  <= t3_item;
      for (int i = 0; i < 3; i++) begin
        t4_fm[i] <= fsum[i][78:DIR_BITS];
      end
      t4_emag  <= emag_next;
      t4_eneg  <= eneg_next;
      for (int i = 0; i < 3; i++) begin
        out_force[i] <= fclip[i][VALUE_WIDTH-1:0];
      end
      out_energy <= eclip[VALUE_WIDTH-1:0];
      out_region <= t4_item.region;
      out_sat    <= fclip[0][VALUE_WIDTH] | fclip[1][VALUE_WIDTH] |
                    fclip[2][VALUE_WIDTH] | eclip[VALUE_WIDTH];
    end
  end

endmodule

// ===== rtl/piecewise_harmonic_pair_force_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_harmonic_pair_force_top
// Pair force vector and energy of a three-region piecewise harmonic potential.
// ----------------------------------------------------------------------------
// Takes one pair per clock unless m_tready stalls the output, and returns one
// result per pair in order, through a 32-stage square root and three
// 64-stage dividers for the unit direction in the front, a one-entry-per-cycle
// queue, then two chained 64-stage dividers (normalized offset, then force
// factor) and the multiply and saturate stages in the back. Configuration is
// written only while no pair is in flight; the user, not the block, sees to it.
module piecewise_harmonic_pair_force_top import pwh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // disp_x, disp_y, disp_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // force_x, force_y, force_z, pair_energy
  output logic [2:0]   m_tuser,   // region, saturated
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_data
);

  cfg_t                        cfg;
  logic                        fr_valid;
  pair_item_t                  fr_item;
  logic                        q_in_ready;
  logic                        q_valid;
  logic                        q_ready;
  pair_item_t                  q_item;
  logic [2:0][VALUE_WIDTH-1:0] force_v;
  logic [VALUE_WIDTH-1:0]      energy;
  region_t                     region;
  logic                        sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spring  <= SPRING_RST;
      cfg.desired <= DESIRED_RST;
      cfg.cutoff  <= CUTOFF_RST;
      cfg.depth   <= DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SPRING:  cfg.spring  <= cfg_data;
        CFG_DESIRED: cfg.desired <= cfg_data;
        CFG_CUTOFF:  cfg.cutoff  <= cfg_data;
        CFG_DEPTH:   cfg.depth   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_disp   (s_tdata),
    .out_valid (fr_valid),
    .out_ready (q_in_ready),
    .out_item  (fr_item)
  );

  pwh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (q_in_ready),
    .in_item   (fr_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  pwh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_force  (force_v),
    .out_energy (energy),
    .out_region (region),
    .out_sat    (sat)
  );

  assign m_tdata = {energy, force_v};
  assign m_tuser = {sat, region};

  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == REGION_NONE) |-> (m_tdata == '0) && !m_tuser[2])
    else $error("nonzero result beyond cutoff");

  a_well_energy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser[1:0] == REGION_INNER) || (m_tuser[1:0] == REGION_OUTER))
    |-> m_tdata[127] || (m_tdata[127:96] == '0))
    else $error("positive energy inside well");

  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> fr_valid && !q_in_ready)
    else $error("front stalled without full queue");

endmodule
